/* rtl/sha512_pkg.sv */
// ============================================================================
// SHA-512 family package
// Shared types, round constants and initial values for the hash engine.
// ============================================================================
package sha512_pkg;

  localparam int unsigned BLOCK_BYTES = 1024 / 8;
  localparam int unsigned LEN_POS     = 896 / 8;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  typedef enum logic [1:0] {
    VAR_SHA512     = 2'd0,
    VAR_SHA384     = 2'd1,
    VAR_SHA512_256 = 2'd2,
    VAR_SHA512_224 = 2'd3
  } variant_t;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // One queued beat between the front end and the core.
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } beat_t;

  typedef logic [63:0] word_t;
  typedef word_t [7:0] chain_t;

  function automatic word_t iv_word(input logic [1:0] v, input logic [2:0] i);
    word_t t [0:31];
    t[0]  = 64'h6a09e667f3bcc908; t[1]  = 64'hbb67ae8584caa73b;
    t[2]  = 64'h3c6ef372fe94f82b; t[3]  = 64'ha54ff53a5f1d36f1;
    t[4]  = 64'h510e527fade682d1; t[5]  = 64'h9b05688c2b3e6c1f;
    t[6]  = 64'h1f83d9abfb41bd6b; t[7]  = 64'h5be0cd19137e2179;
    t[8]  = 64'hcbbb9d5dc1059ed8; t[9]  = 64'h629a292a367cd507;
    t[10] = 64'h9159015a3070dd17; t[11] = 64'h152fecd8f70e5939;
    t[12] = 64'h67332667ffc00b31; t[13] = 64'h8eb44a8768581511;
    t[14] = 64'hdb0c2e0d64f98fa7; t[15] = 64'h47b5481dbefa4fa4;
    t[16] = 64'h22312194fc2bf72c; t[17] = 64'h9f555fa3c84c64c2;
    t[18] = 64'h2393b86b6f53b151; t[19] = 64'h963877195940eabd;
    t[20] = 64'h96283ee2a88effe3; t[21] = 64'hbe5e1e2553863992;
    t[22] = 64'h2b0199fc2c85b8aa; t[23] = 64'h0eb72ddc81c52ca2;
    t[24] = 64'h8c3d37c819544da2; t[25] = 64'h73e1996689dcd4d6;
    t[26] = 64'h1dfab7ae32ff9c82; t[27] = 64'h679dd514582f9fcf;
    t[28] = 64'h0f6d2b697bd44da8; t[29] = 64'h77e36f7304c48942;
    t[30] = 64'h3f9d85a86a1d36c8; t[31] = 64'h1112e6ad91d692a1;
    return t[{v, i}];
  endfunction

  function automatic word_t round_k(input logic [6:0] r);
    word_t k;
    case (r)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

/* rtl/sha512_fifo.sv */
// ============================================================================
// SHA-512 beat queue
// Small register queue that decouples the input channel from the core.
// ============================================================================
module sha512_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               flush,
  input  logic               wr_en,
  input  sha512_pkg::beat_t  wr_data,
  output logic               full,
  input  logic               rd_en,
  output sha512_pkg::beat_t  rd_data,
  output logic               empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha512_pkg::beat_t    mem_r [DEPTH];
  logic [AW-1:0]        wp_r, rp_r;
  logic [AW:0]          cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= inc(wp_r);
      if (rd_en && !empty) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (full && !rd_en && !flush) |=> full)
    else $error("full queue drained without a read");
  assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !wr_en && !flush) |=> empty)
    else $error("empty queue filled without a write");
endmodule

/* rtl/sha512_round.sv */
// ============================================================================
// SHA-512 compression unit
// One round per cycle, with a 16-word rolling schedule.
// ============================================================================
module sha512_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sha512_pkg::chain_t  chain_in,
  input  logic [1023:0]       block_in,
  output logic                busy,
  output logic                done,
  output sha512_pkg::chain_t  chain_out
);
  logic [6:0]             rnd_r;
  logic                   busy_r, done_r;
  sha512_pkg::word_t      w_r [16];
  sha512_pkg::chain_t     st_r, base_r;
  sha512_pkg::word_t      s0, s1, wn, t1, t2, a, b, c, e, f, g, h, d;

  assign busy = busy_r;
  assign done = done_r;
  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[i] = base_r[i];
  end

  always_comb begin
    s0 = sha512_pkg::rotr(w_r[1], 1) ^ sha512_pkg::rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1 = sha512_pkg::rotr(w_r[14], 19) ^ sha512_pkg::rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    wn = w_r[0] + s0 + w_r[9] + s1;
    a = st_r[0]; b = st_r[1]; c = st_r[2]; d = st_r[3];
    e = st_r[4]; f = st_r[5]; g = st_r[6]; h = st_r[7];
    t1 = h + (sha512_pkg::rotr(e, 14) ^ sha512_pkg::rotr(e, 18) ^ sha512_pkg::rotr(e, 41))
         + ((e & f) ^ (~e & g)) + sha512_pkg::round_k(rnd_r) + w_r[0];
    t2 = (sha512_pkg::rotr(a, 28) ^ sha512_pkg::rotr(a, 34) ^ sha512_pkg::rotr(a, 39))
         + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        for (int i = 0; i < 16; i++) w_r[i] <= block_in[1023 - 64*i -: 64];
        for (int i = 0; i < 8; i++) begin
          st_r[i]   <= chain_in[i];
          base_r[i] <= chain_in[i];
        end
      end else if (busy_r) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        st_r[7] <= g; st_r[6] <= f; st_r[5] <= e; st_r[4] <= d + t1;
        st_r[3] <= c; st_r[2] <= b; st_r[1] <= a; st_r[0] <= t1 + t2;
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          // Fold in the working state as it stands after the last round.
          base_r[0] <= base_r[0] + t1 + t2; base_r[1] <= base_r[1] + a;
          base_r[2] <= base_r[2] + b;       base_r[3] <= base_r[3] + c;
          base_r[4] <= base_r[4] + d + t1;  base_r[5] <= base_r[5] + e;
          base_r[6] <= base_r[6] + f;       base_r[7] <= base_r[7] + g;
        end else begin
          rnd_r <= rnd_r + 7'd1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rnd_r <= 7'd79)
    else $error("round counter out of range");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && rnd_r == 7'd79) |=> done_r)
    else $error("final round without done");
endmodule

/* rtl/sha512_core.sv */
// ============================================================================
// SHA-512 back end
// Buffers bytes, pads, drives the compression unit and emits digest words.
// ============================================================================
module sha512_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_var,
  input  logic               q_empty,
  input  sha512_pkg::beat_t  q_data,
  output logic               q_rd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic [3:0]         out_valid_bytes,
  output logic               out_last,
  output logic               out_too_long
);
  typedef enum logic [2:0] {
    ST_ABSORB, ST_COMP, ST_PAD, ST_LEN, ST_FINAL, ST_EMIT
  } state_t;

  localparam logic [60:0] COUNT_MAX = '1;

  state_t               st_r;
  logic [1:0]           var_r;
  logic [63:0]          buf_r [16];
  logic [6:0]           fill_r;
  logic [60:0]          cnt_r;
  logic                 ovf_r;
  sha512_pkg::chain_t   cv_r;
  logic [2:0]           idx_r;
  logic                 start_r;
  logic [1023:0]        blk;
  logic                 rbusy, rdone;
  sha512_pkg::chain_t   rout;
  logic [2:0]           nlast;
  logic                 valid_r;
  logic [63:0]          bits;

  // The block is held as 16 big-endian words; byte n sits in word n/8.
  always_comb begin
    for (int i = 0; i < 16; i++) blk[1023 - 64*i -: 64] = buf_r[i];
  end
  assign bits = {cnt_r, 3'b000};

  sha512_round u_round (
    .clk(clk), .rst_n(rst_n), .start(start_r), .chain_in(cv_r), .block_in(blk),
    .busy(rbusy), .done(rdone), .chain_out(rout)
  );

  always_comb begin
    case (sha512_pkg::variant_t'(var_r))
      sha512_pkg::VAR_SHA512:  nlast = 3'd7;
      sha512_pkg::VAR_SHA384:  nlast = 3'd5;
      default:                 nlast = 3'd3;
    endcase
  end

  assign q_rd      = (st_r == ST_ABSORB) && !q_empty && !cfg_wr;
  assign out_valid = valid_r;
  always_comb begin
    out_word_index  = idx_r;
    out_last        = (idx_r == nlast);
    out_too_long    = ovf_r;
    if ((sha512_pkg::variant_t'(var_r) == sha512_pkg::VAR_SHA512_224) && idx_r == 3'd3) begin
      out_digest_word = {cv_r[idx_r][63:32], 32'h0};
      out_valid_bytes = 4'd4;
    end else begin
      out_digest_word = cv_r[idx_r];
      out_valid_bytes = 4'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && !q_data.finish) begin
      for (int j = 0; j < 8; j++)
        if (3'(j) == fill_r[2:0]) buf_r[fill_r[6:3]][63 - 8*j -: 8] <= q_data.data;
    end else if (st_r == ST_ABSORB && q_rd && q_data.finish) begin
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 8; j++) begin
          if (7'(8*i + j) == fill_r) buf_r[i][63 - 8*j -: 8] <= sha512_pkg::PAD_BYTE;
          else if (7'(8*i + j) > fill_r) buf_r[i][63 - 8*j -: 8] <= 8'h00;
        end
      end
    end else if (st_r == ST_PAD) begin
      for (int i = 0; i < 16; i++) buf_r[i] <= '0;
    end else if (st_r == ST_LEN) begin
      buf_r[15] <= bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_ABSORB;
      var_r   <= 2'd0;
      fill_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      start_r <= 1'b0;
      valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) cv_r[i] <= sha512_pkg::iv_word(2'd0, 3'(i));
    end else if (cfg_wr) begin
      st_r    <= ST_ABSORB;
      var_r   <= cfg_var;
      fill_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      start_r <= 1'b0;
      valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) cv_r[i] <= sha512_pkg::iv_word(cfg_var, 3'(i));
    end else begin
      start_r <= 1'b0;
      case (st_r)
        ST_ABSORB: begin
          if (q_rd) begin
            if (!q_data.finish) begin
              fill_r <= fill_r + 7'd1;
              if (cnt_r == COUNT_MAX) ovf_r <= 1'b1;
              else cnt_r <= cnt_r + 61'd1;
              if (fill_r == 7'd127) begin
                start_r <= 1'b1;
                st_r    <= ST_COMP;
              end
            end else if (fill_r >= 7'(sha512_pkg::LEN_POS)) begin
              start_r <= 1'b1;
              st_r    <= ST_PAD;
            end else begin
              st_r <= ST_LEN;
            end
          end
        end
        ST_COMP: begin
          if (rdone) begin
            cv_r <= rout;
            st_r <= ST_ABSORB;
          end
        end
        ST_PAD: begin
          // Buffer is cleared here once the first pad block was captured.
          if (rdone) begin
            cv_r <= rout;
            st_r <= ST_LEN;
          end
        end
        ST_LEN: begin
          start_r <= 1'b1;
          st_r    <= ST_FINAL;
        end
        ST_FINAL: begin
          if (rdone) begin
            cv_r    <= rout;
            idx_r   <= '0;
            valid_r <= 1'b1;
            st_r    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            if (idx_r == nlast) begin
              valid_r <= 1'b0;
              fill_r  <= '0;
              cnt_r   <= '0;
              ovf_r   <= 1'b0;
              st_r    <= ST_ABSORB;
              for (int i = 0; i < 8; i++) cv_r[i] <= sha512_pkg::iv_word(var_r, 3'(i));
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: st_r <= ST_ABSORB;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) valid_r |-> st_r == ST_EMIT)
    else $error("result valid outside emit");
  assert property (@(posedge clk) disable iff (!rst_n) q_rd |-> !rbusy)
    else $error("queue read during compression");
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall && !cfg_wr) |=> (valid_r && $stable(idx_r)))
    else $error("stalled result changed");
endmodule

/* rtl/sha512_family_hash_engine_top.sv */
// ============================================================================
// SHA-512 family hash engine, top level
// Front queue feeding a padding and compression back end.
// ============================================================================
// Usage: write the variant on cfg_wr_en/cfg_wr_data while idle; a write
// reloads the initial value and drops any partial message. Input beats carry
// in_cmd (absorb byte or finish) and in_data_byte on in_valid/in_stall. Beats
// land in a small queue, so the input side can keep flowing while the core
// works, until the queue fills. The core absorbs one byte per cycle while
// the queue holds beats; each full block then holds the core while the
// single-round compression unit runs, during which the queue fills and
// in_stall rises. A finish costs one or two compressions and then emits
// 4, 6 or 8 digest words, one per cycle while out_stall is low. A stalled
// word holds still until taken. The round unit sets throughput, since the
// core absorbs no bytes while a block is being compressed.
// Reset selects SHA-512 and clears the message state and the queue.
// ============================================================================
module sha512_family_hash_engine_top #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last,
  output logic        out_too_long
);
  sha512_pkg::beat_t wbeat, rbeat;
  logic full, empty, rd;

  assign wbeat.finish = (sha512_pkg::cmd_t'(in_cmd) == sha512_pkg::CMD_FINISH);
  assign wbeat.data   = in_data_byte;
  assign in_stall     = full;

  sha512_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .flush(cfg_wr_en), .wr_en(in_valid), .wr_data(wbeat),
    .full(full), .rd_en(rd), .rd_data(rbeat), .empty(empty)
  );

  sha512_core u_core (
    .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_wr_en), .cfg_var(cfg_wr_data),
    .q_empty(empty), .q_data(rbeat), .q_rd(rd),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_valid_bytes(out_valid_bytes),
    .out_last(out_last), .out_too_long(out_too_long)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall && !cfg_wr_en) |=> !out_valid)
    else $error("valid after last word");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bytes == 4'd8 || out_valid_bytes == 4'd4))
    else $error("bad valid byte count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_bytes == 4'd4) |-> out_last)
    else $error("half word not last");
endmodule
